/* src/ffba_pkg.sv */
// Shared types and constants of the first-fit block allocator.
// No dependencies; used by ffba_cell and first_fit_block_allocator.
`default_nettype none

package ffba_pkg;

  localparam int HEADER_BYTES    = 32;
  localparam int PAGE_BYTES      = 4096;
  localparam int MAX_BLOCKS_DEF  = 64;
  localparam int ARENA_MAX_BYTES = 1048576;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_UNINIT  = 3'd1,
    ST_NOMEM   = 3'd2,
    ST_BADPTR  = 3'd3,
    ST_DBLFREE = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    OP_NOP = 2'd0,
    OP_WR  = 2'd1,
    OP_INS = 2'd2,
    OP_DEL = 2'd3
  } op_t;

  typedef struct packed {
    logic [19:0] start;
    logic [20:0] len;
    logic        free;
  } entry_t;

  typedef struct packed {
    op_t    op;
    entry_t ent;
  } cmd_t;

  // token walking the chain; ent is the entry of the cell it just left
  typedef struct packed {
    logic   vld;
    entry_t ent;
  } tok_t;

  typedef struct packed {
    logic        is_free;
    logic [21:0] size;
    logic [19:0] ptr;
  } key_t;

  typedef struct packed {
    entry_t cur;
    entry_t prev;
    logic   next_vld;
    entry_t next;
  } rpt_t;

endpackage

`default_nettype wire

/* src/ffba_cell.sv */
// One cell of the block table chain: holds one entry, shifts with its
// neighbors and checks the search token. Depends on ffba_pkg.
`default_nettype none

module ffba_cell import ffba_pkg::*; #(
  parameter int MAX_BLOCKS = MAX_BLOCKS_DEF,
  parameter int CELL_IDX   = 0,
  localparam int IW = $clog2(MAX_BLOCKS),
  localparam int CW = $clog2(MAX_BLOCKS + 1)
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire cmd_t          cmd,
  input  wire logic [IW-1:0] cmd_idx,
  input  wire logic [CW-1:0] count,
  input  wire key_t          key,
  input  wire tok_t          tok_in,
  output tok_t               tok_out,
  input  wire entry_t        left_ent,
  input  wire entry_t        right_ent,
  output entry_t             ent_out,
  output logic               hit,
  output logic               miss,
  output rpt_t               rpt
);

  localparam logic [IW-1:0] MY_IDX = IW'(CELL_IDX);
  localparam logic [CW-1:0] MY_POS = CW'(CELL_IDX);
  localparam logic [CW-1:0] NX_POS = CW'(CELL_IDX + 1);

  entry_t ent_r, ent_nxt;
  tok_t   tok_r;
  logic   in_rng, match;

  always_comb begin
    ent_nxt = ent_r;
    case (cmd.op)
      OP_WR: begin
        if (cmd_idx == MY_IDX) ent_nxt = cmd.ent;
      end
      OP_INS: begin
        if (MY_IDX > cmd_idx) ent_nxt = left_ent;
      end
      OP_DEL: begin
        if (MY_IDX >= cmd_idx) ent_nxt = right_ent;
      end
      default: ent_nxt = ent_r;
    endcase
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= '0;
    end else begin
      tok_r <= tok_in;
    end
  end

  assign in_rng = MY_POS < count;
  assign match  = key.is_free ? ((ent_r.start + 20'(HEADER_BYTES)) == key.ptr)
                              : (ent_r.free && ({1'b0, ent_r.len} >= key.size));

  assign hit          = tok_r.vld & in_rng & match;
  assign miss         = tok_r.vld & ~in_rng;
  assign tok_out.vld  = tok_r.vld & in_rng & ~match;
  assign tok_out.ent  = ent_r;
  assign ent_out      = ent_r;

  always_comb begin
    rpt = '0;
    if (hit) begin
      rpt.cur      = ent_r;
      rpt.prev     = tok_r.ent;
      rpt.next_vld = NX_POS < count;
      rpt.next     = right_ent;
    end
  end

endmodule

`default_nettype wire

/* src/first_fit_block_allocator.sv */
// Top level of the first-fit block allocator: request control, APB register
// and the chain of ffba_cell entries. Depends on ffba_pkg and ffba_cell.
//
// Usage:
//   Requests enter on in_* (valid/stall); one result leaves per request on
//   out_* (valid/stall). arena_bytes is written over the APB port at address 0
//   while no request is in flight; a nonzero size up to ARENA_MAX_BYTES
//   makes one free block. A request is answered early (uninitialized, null
//   pointer, not enough bytes); otherwise the search token walks from cell 0
//   to the matching cell k (one cell per cycle), then up to 3 table
//   shifts/writes are done and the result goes into the output register. One
//   request is worked on at a time; the next one is taken in the cycle after
//   the result is parked in the output register.
//   When the receiver stalls, the result holds in out_* and a finished
//   request waits before its result is loaded.
//   Reset clears the control state, block count, bytes left and arena size;
//   in_stall is high during reset. Table entries are written before they
//   are ever read.
`default_nettype none

module first_fit_block_allocator import ffba_pkg::*; #(
  parameter int MAX_BLOCKS = MAX_BLOCKS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_req_type,
  input  wire logic [20:0] in_req_size,
  input  wire logic [19:0] in_ptr_offset,
  input  wire logic        in_ptr_null,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       out_status,
  output logic [19:0]      out_payload_offset,
  output logic [20:0]      out_bytes_left,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int IW = $clog2(MAX_BLOCKS);
  localparam int CW = $clog2(MAX_BLOCKS + 1);
  localparam logic [20:0] HDR21 = 21'(HEADER_BYTES);
  localparam logic [19:0] HDR20 = 20'(HEADER_BYTES);
  localparam logic REG_ARENA = 1'b0;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_CHK  = 6'b000010,
    S_SRCH = 6'b000100,
    S_PLAN = 6'b001000,
    S_EXEC = 6'b010000,
    S_FIN  = 6'b100000
  } state_t;

  state_t        state_r, state_nxt;
  logic [20:0]   arena_r, arena_nxt;
  logic [20:0]   rem_r, rem_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  key_t          key_r;
  logic          null_r;
  rpt_t          cur_r;
  logic [IW-1:0] idx_r;
  status_t       status_r, status_nxt;
  logic [19:0]   pay_r, pay_nxt;
  cmd_t          cmdq_r [3];
  cmd_t          cmdq_nxt [3];
  logic [IW-1:0] cidx_r [3];
  logic [IW-1:0] cidx_nxt [3];
  logic [1:0]    ncmd_r, ncmd_nxt;
  logic [1:0]    step_r, step_nxt;
  logic          out_vld_r;
  status_t       out_status_r;
  logic [19:0]   out_pay_r;
  logic [20:0]   out_left_r;

  cmd_t          cell_cmd;
  logic [IW-1:0] cell_idx;
  tok_t          tok_a [MAX_BLOCKS+1];
  entry_t        ent_a [MAX_BLOCKS];
  logic [MAX_BLOCKS-1:0] hit_v, miss_v;
  rpt_t          rpt_a [MAX_BLOCKS];
  rpt_t          rpt_or;
  logic [IW-1:0] hit_idx;
  logic          hit_any, miss_any;

  logic          accept, cfg_wr, cfg_load, out_free;
  logic [20:0]   cfg_v;
  logic [21:0]   cfg_rnd;

  // cell chain
  for (genvar k = 0; k < MAX_BLOCKS; k++) begin : g_cell
    ffba_cell #(.MAX_BLOCKS(MAX_BLOCKS), .CELL_IDX(k)) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cmd       (cell_cmd),
      .cmd_idx   (cell_idx),
      .count     (cnt_r),
      .key       (key_r),
      .tok_in    (tok_a[k]),
      .tok_out   (tok_a[k+1]),
      .left_ent  ((k == 0) ? entry_t'('0) : ent_a[(k == 0) ? 0 : k-1]),
      .right_ent ((k == MAX_BLOCKS-1) ? entry_t'('0)
                                       : ent_a[(k == MAX_BLOCKS-1) ? k : k+1]),
      .ent_out   (ent_a[k]),
      .hit       (hit_v[k]),
      .miss      (miss_v[k]),
      .rpt       (rpt_a[k])
    );
  end

  always_comb begin
    rpt_or  = '0;
    hit_idx = '0;
    for (int k = 0; k < MAX_BLOCKS; k++) begin
      rpt_or = rpt_or | rpt_a[k];
      if (hit_v[k]) hit_idx = hit_idx | IW'(k);
    end
  end

  assign hit_any  = |hit_v;
  assign miss_any = (|miss_v) | tok_a[MAX_BLOCKS].vld;

  // handshakes and register port
  assign in_stall  = (state_r != S_IDLE) | ~rst_n;
  assign accept    = in_valid & ~in_stall;
  assign out_free  = ~out_vld_r | ~out_stall;
  assign pready    = 1'b1;
  assign prdata    = (paddr[2] == REG_ARENA) ? {11'b0, arena_r} : 32'b0;
  assign cfg_wr    = psel & penable & pwrite & (paddr[2] == REG_ARENA);
  assign cfg_v     = pwdata[20:0];
  assign cfg_rnd   = ({1'b0, cfg_v} + 22'(PAGE_BYTES - 1)) & ~22'(PAGE_BYTES - 1);
  assign cfg_load  = cfg_wr && (cfg_v != 21'b0) && (cfg_v <= 21'(ARENA_MAX_BYTES))
                     && (cfg_rnd <= 22'(ARENA_MAX_BYTES));

  always_comb begin
    cell_cmd = '0;
    cell_idx = '0;
    if (cfg_load) begin
      cell_cmd.op        = OP_WR;
      cell_cmd.ent.start = '0;
      cell_cmd.ent.len   = cfg_rnd[20:0] - HDR21;
      cell_cmd.ent.free  = 1'b1;
    end else if (state_r == S_EXEC) begin
      cell_cmd = cmdq_r[step_r];
      cell_idx = cidx_r[step_r];
    end
  end

  // control
  logic [20:0] rest;
  logic        split;
  logic [21:0] used;
  logic [22:0] rem_sum;
  logic        mrg_n, mrg_p;

  always_comb begin
    state_nxt  = state_r;
    arena_nxt  = arena_r;
    rem_nxt    = rem_r;
    cnt_nxt    = cnt_r;
    status_nxt = status_r;
    pay_nxt    = pay_r;
    cmdq_nxt   = cmdq_r;
    cidx_nxt   = cidx_r;
    ncmd_nxt   = ncmd_r;
    step_nxt   = step_r;
    tok_a[0]   = '0;
    rest       = cur_r.cur.len - key_r.size[20:0];
    split      = (rest >= HDR21) && (cnt_r < CW'(MAX_BLOCKS));
    used       = split ? ({1'b0, key_r.size[20:0]} + 22'(HEADER_BYTES))
                       : ({1'b0, cur_r.cur.len} + 22'(HEADER_BYTES));
    rem_sum    = {2'b0, rem_r} + {2'b0, cur_r.cur.len} + 23'(HEADER_BYTES);
    mrg_n      = cur_r.next_vld & cur_r.next.free;
    mrg_p      = cur_r.prev.free;

    case (state_r)
      S_IDLE: begin
        if (accept) state_nxt = S_CHK;
      end
      S_CHK: begin
        pay_nxt = '0;
        if (arena_r == 21'b0) begin
          status_nxt = ST_UNINIT;
          state_nxt  = S_FIN;
        end else if (key_r.is_free && null_r) begin
          status_nxt = ST_BADPTR;
          state_nxt  = S_FIN;
        end else if (!key_r.is_free &&
                     (({1'b0, key_r.size} + 23'(HEADER_BYTES)) > {2'b0, rem_r})) begin
          status_nxt = ST_NOMEM;
          state_nxt  = S_FIN;
        end else begin
          tok_a[0].vld = 1'b1;
          state_nxt    = S_SRCH;
        end
      end
      S_SRCH: begin
        if (hit_any) begin
          state_nxt = S_PLAN;
        end else if (miss_any) begin
          status_nxt = key_r.is_free ? ST_BADPTR : ST_NOMEM;
          state_nxt  = S_FIN;
        end
      end
      S_PLAN: begin
        step_nxt   = '0;
        status_nxt = ST_OK;
        pay_nxt    = '0;
        ncmd_nxt   = 2'd1;
        for (int q = 0; q < 3; q++) begin
          cmdq_nxt[q] = '0;
          cidx_nxt[q] = idx_r;
        end
        if (!key_r.is_free) begin
          pay_nxt = cur_r.cur.start + HDR20;
          rem_nxt = ({1'b0, rem_r} < used) ? 21'b0 : 21'({1'b0, rem_r} - used);
          if (split) begin
            cmdq_nxt[0].op        = OP_INS;
            cidx_nxt[0]           = idx_r + 1'b1;
            cmdq_nxt[1].op        = OP_WR;
            cidx_nxt[1]           = idx_r + 1'b1;
            cmdq_nxt[1].ent.start = cur_r.cur.start + HDR20 + key_r.size[19:0];
            cmdq_nxt[1].ent.len   = rest - HDR21;
            cmdq_nxt[1].ent.free  = 1'b1;
            cmdq_nxt[2].op        = OP_WR;
            cmdq_nxt[2].ent.start = cur_r.cur.start;
            cmdq_nxt[2].ent.len   = key_r.size[20:0];
            cmdq_nxt[2].ent.free  = 1'b0;
            ncmd_nxt              = 2'd3;
            cnt_nxt               = cnt_r + 1'b1;
          end else begin
            cmdq_nxt[0].op        = OP_WR;
            cmdq_nxt[0].ent       = cur_r.cur;
            cmdq_nxt[0].ent.free  = 1'b0;
          end
          state_nxt = S_EXEC;
        end else if (cur_r.cur.free) begin
          status_nxt = ST_DBLFREE;
          state_nxt  = S_FIN;
        end else begin
          rem_nxt = (rem_sum > {2'b0, arena_r}) ? arena_r : rem_sum[20:0];
          cmdq_nxt[0].op = OP_WR;
          if (mrg_p && mrg_n) begin
            cidx_nxt[0]           = idx_r - 1'b1;
            cmdq_nxt[0].ent.start = cur_r.prev.start;
            cmdq_nxt[0].ent.len   = cur_r.prev.len + cur_r.cur.len + cur_r.next.len
                                    + 21'(2 * HEADER_BYTES);
            cmdq_nxt[1].op        = OP_DEL;
            cmdq_nxt[2].op        = OP_DEL;
            ncmd_nxt              = 2'd3;
            cnt_nxt               = cnt_r - CW'(2);
          end else if (mrg_n) begin
            cmdq_nxt[0].ent.start = cur_r.cur.start;
            cmdq_nxt[0].ent.len   = cur_r.cur.len + cur_r.next.len + HDR21;
            cmdq_nxt[1].op        = OP_DEL;
            cidx_nxt[1]           = idx_r + 1'b1;
            ncmd_nxt              = 2'd2;
            cnt_nxt               = cnt_r - 1'b1;
          end else if (mrg_p) begin
            cidx_nxt[0]           = idx_r - 1'b1;
            cmdq_nxt[0].ent.start = cur_r.prev.start;
            cmdq_nxt[0].ent.len   = cur_r.prev.len + cur_r.cur.len + HDR21;
            cmdq_nxt[1].op        = OP_DEL;
            ncmd_nxt              = 2'd2;
            cnt_nxt               = cnt_r - 1'b1;
          end else begin
            cmdq_nxt[0].ent.start = cur_r.cur.start;
            cmdq_nxt[0].ent.len   = cur_r.cur.len;
          end
          cmdq_nxt[0].ent.free = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        step_nxt = step_r + 1'b1;
        if (step_r == ncmd_r - 1'b1) state_nxt = S_FIN;
      end
      S_FIN: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase

    if (cfg_wr) begin
      if (cfg_v == 21'b0) begin
        arena_nxt = '0;
        rem_nxt   = '0;
        cnt_nxt   = '0;
      end else if (cfg_load) begin
        arena_nxt = cfg_rnd[20:0];
        rem_nxt   = cfg_rnd[20:0];
        cnt_nxt   = CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      arena_r   <= '0;
      rem_r     <= '0;
      cnt_r     <= '0;
      ncmd_r    <= '0;
      step_r    <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      arena_r <= arena_nxt;
      rem_r   <= rem_nxt;
      cnt_r   <= cnt_nxt;
      ncmd_r  <= ncmd_nxt;
      step_r  <= step_nxt;
      if (state_r == S_FIN && out_free) begin
        out_vld_r <= 1'b1;
      end else if (~out_stall) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    pay_r    <= pay_nxt;
    cmdq_r   <= cmdq_nxt;
    cidx_r   <= cidx_nxt;
    if (accept) begin
      key_r.is_free <= in_req_type;
      key_r.size    <= ({1'b0, in_req_size} + 22'(HEADER_BYTES - 1))
                       & ~22'(HEADER_BYTES - 1);
      key_r.ptr     <= in_ptr_offset;
      null_r        <= in_ptr_null;
    end
    if (state_r == S_SRCH && hit_any) begin
      cur_r <= rpt_or;
      idx_r <= hit_idx;
    end
    if (state_r == S_FIN && out_free) begin
      out_status_r <= status_r;
      out_pay_r    <= pay_r;
      out_left_r   <= rem_r;
    end
  end

  assign out_valid          = out_vld_r;
  assign out_status         = out_status_r;
  assign out_payload_offset = out_pay_r;
  assign out_bytes_left     = out_left_r;

`ifndef NO_ASSERTIONS
  a_one_probe: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({hit_v, miss_v}))
    else $error("more than one cell answered the search");
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(MAX_BLOCKS))
    else $error("block count above table size");
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    rem_r <= arena_r)
    else $error("bytes left above arena size");
  a_srch_only: assert property (@(posedge clk) disable iff (!rst_n)
    (hit_any || miss_any) |-> (state_r == S_SRCH))
    else $error("cell answered outside a search");
`endif

endmodule

`default_nettype wire
